FILE: rtl/armn_pkg.sv
// ----------------------------------------------------------------------------
// Auto-range motion normalizer package
// Shared widths, constants, register indexes and the divider interface types.
// ----------------------------------------------------------------------------
package armn_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int OUT_W        = 15;
    localparam int PCT_W        = 7;
    localparam int QUO_W        = 15;
    localparam int NUM_W        = SAMPLE_WIDTH + QUO_W;
    localparam int DEN_W        = SAMPLE_WIDTH;
    localparam int PROD_W       = OUT_W + PCT_W + 1;
    localparam int CNT_W        = $clog2(QUO_W);
    localparam int CFG_IDX_W    = 1;

    localparam int MAP_SPAN     = 20000;
    localparam int MAP_OFFSET   = 10000;
    localparam int PERCENT_FULL = 100;

    // Division by the full percent is a multiply by ceil(2^27 / 100) and a
    // shift by 27, exact for every gain product up to 10000 * 100.
    localparam int PCT_RECIP_W     = 21;
    localparam int PCT_RECIP_SHIFT = 27;
    localparam int RCP_PROD_W      = PROD_W + PCT_RECIP_W;
    localparam logic [PCT_RECIP_W-1:0] PCT_RECIP = 21'd1342178;

    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_PERCENT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROLL_PERCENT  = 1'b1;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] numer;
        logic [DEN_W-1:0] denom;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } div_rsp_t;

endpackage

FILE: rtl/armn_divider.sv
// ----------------------------------------------------------------------------
// Auto-range motion normalizer divider
// Restoring divider that produces one quotient bit per cycle, shared by the
// range mapping of both axes.
// ----------------------------------------------------------------------------
module armn_divider
(
    input  logic               clk,
    input  logic               rst_n,
    input  armn_pkg::div_req_t req,
    output armn_pkg::div_rsp_t rsp
);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [armn_pkg::CNT_W-1:0]     count_reg, count_next;
    logic [armn_pkg::NUM_W-1:0]     rem_reg, rem_next;
    logic [armn_pkg::NUM_W-1:0]     dsh_reg, dsh_next;
    logic [armn_pkg::QUO_W-1:0]     quo_reg, quo_next;
    logic                           fits;

    assign fits = (rem_reg >= dsh_reg);

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        dsh_next   = dsh_reg;
        quo_next   = quo_reg;
        if (req.start)
        begin
            busy_next  = 1'b1;
            count_next = armn_pkg::CNT_W'(armn_pkg::QUO_W - 1);
            rem_next   = req.numer;
            dsh_next   = armn_pkg::NUM_W'(req.denom) << (armn_pkg::QUO_W - 1);
            quo_next   = '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = rem_reg - dsh_reg;
            end
            quo_next = {quo_reg[armn_pkg::QUO_W-2:0], fits};
            dsh_next = dsh_reg >> 1;
            if (count_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
            rem_reg   <= '0;
            dsh_reg   <= '0;
            quo_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
            rem_reg   <= rem_next;
            dsh_reg   <= dsh_next;
            quo_reg   <= quo_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

FILE: rtl/auto_range_motion_normalizer.sv
// ----------------------------------------------------------------------------
// Auto-range motion normalizer
// Tracks a running range per axis, maps each sample onto -10000..10000 and
// applies a percent gain, giving pitch and roll drive values.
// ----------------------------------------------------------------------------
//  Channel  Handshake           Payload
//  in       in_valid/in_ready   longitudinal_milli_g, lateral_milli_g
//  out      out_valid/out_ready pitch_drive, roll_drive
//  cfg      cfg_valid/cfg_ready cfg_index, cfg_data
//
// A sample holds off the next input transaction until it is through: per axis
// a range update, a division in the shared divider at one quotient bit a cycle,
// gain scaling (a percent product, then a reciprocal multiply), then delivery.
// Reset sets the low marks to 0, the high marks to 1 and both gains to 100.
// A result waiting on out_ready does not block the next input transaction;
// only the following result waits for the output register to free up.
// ----------------------------------------------------------------------------
module auto_range_motion_normalizer
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [armn_pkg::SAMPLE_WIDTH-1:0] longitudinal_milli_g,
    input  logic signed [armn_pkg::SAMPLE_WIDTH-1:0] lateral_milli_g,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [armn_pkg::OUT_W-1:0]       pitch_drive,
    output logic signed [armn_pkg::OUT_W-1:0]       roll_drive,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [armn_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [armn_pkg::PCT_W-1:0]              cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MARK,
        ST_DIV_MAP,
        ST_SCALE,
        ST_DIV_GAIN,
        ST_DELIVER
    } state_t;

    typedef enum logic {
        AXIS_PITCH,
        AXIS_ROLL
    } axis_t;

    localparam int SW = armn_pkg::SAMPLE_WIDTH;

    state_t                                state_reg, state_next;
    axis_t                                 axis_reg, axis_next;
    logic signed [SW-1:0]                  lon_reg, lon_next;
    logic signed [SW-1:0]                  lat_reg, lat_next;
    logic signed [SW-1:0]                  pitch_lo_reg, pitch_lo_next;
    logic signed [SW-1:0]                  pitch_hi_reg, pitch_hi_next;
    logic signed [SW-1:0]                  roll_lo_reg, roll_lo_next;
    logic signed [SW-1:0]                  roll_hi_reg, roll_hi_next;
    logic [armn_pkg::PCT_W-1:0]            pitch_pct_reg, pitch_pct_next;
    logic [armn_pkg::PCT_W-1:0]            roll_pct_reg, roll_pct_next;
    logic signed [armn_pkg::OUT_W-1:0]     mapped_reg, mapped_next;
    logic                                  neg_reg, neg_next;
    logic [armn_pkg::PROD_W-1:0]           mag_reg, mag_next;
    logic signed [armn_pkg::OUT_W-1:0]     res_pitch_reg, res_pitch_next;
    logic signed [armn_pkg::OUT_W-1:0]     res_roll_reg, res_roll_next;
    logic signed [armn_pkg::OUT_W-1:0]     pitch_out_reg, pitch_out_next;
    logic signed [armn_pkg::OUT_W-1:0]     roll_out_reg, roll_out_next;
    logic                                  out_valid_reg, out_valid_next;
    armn_pkg::div_req_t                    div_req_reg, div_req_next;
    armn_pkg::div_rsp_t                    div_rsp;

    logic signed [SW-1:0]                  cur_s, cur_lo, cur_hi, lo_new, hi_new;
    logic signed [SW:0]                    diff_wide, span_wide;
    logic [armn_pkg::PCT_W-1:0]            pct_sel, pct_clamped;
    logic signed [armn_pkg::PROD_W-1:0]    prod;
    logic [armn_pkg::PROD_W-1:0]           prod_mag;
    logic [armn_pkg::RCP_PROD_W-1:0]       recip_prod;
    logic signed [armn_pkg::OUT_W-1:0]     quo_signed, drive;

    armn_divider u_divider
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req_reg),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        cur_s     = (axis_reg == AXIS_PITCH) ? lon_reg : lat_reg;
        cur_lo    = (axis_reg == AXIS_PITCH) ? pitch_lo_reg : roll_lo_reg;
        cur_hi    = (axis_reg == AXIS_PITCH) ? pitch_hi_reg : roll_hi_reg;
        lo_new    = (cur_s < cur_lo) ? cur_s : cur_lo;
        hi_new    = (cur_s > cur_hi) ? cur_s : cur_hi;
        diff_wide = {cur_s[SW-1], cur_s} - {lo_new[SW-1], lo_new};
        span_wide = {hi_new[SW-1], hi_new} - {lo_new[SW-1], lo_new};
        pct_sel   = (axis_reg == AXIS_PITCH) ? pitch_pct_reg : roll_pct_reg;
        pct_clamped = (pct_sel > armn_pkg::PCT_W'(armn_pkg::PERCENT_FULL))
                      ? armn_pkg::PCT_W'(armn_pkg::PERCENT_FULL) : pct_sel;
        prod      = armn_pkg::PROD_W'(mapped_reg) *
                    armn_pkg::PROD_W'($signed({1'b0, pct_clamped}));
        prod_mag  = prod[armn_pkg::PROD_W-1] ? armn_pkg::PROD_W'(-prod)
                                             : armn_pkg::PROD_W'(prod);
        recip_prod = armn_pkg::RCP_PROD_W'(mag_reg) *
                     armn_pkg::RCP_PROD_W'(armn_pkg::PCT_RECIP);
        quo_signed = $signed(recip_prod[armn_pkg::PCT_RECIP_SHIFT +: armn_pkg::OUT_W]);
        drive     = neg_reg ? -quo_signed : quo_signed;
    end

    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        lon_next       = lon_reg;
        lat_next       = lat_reg;
        pitch_lo_next  = pitch_lo_reg;
        pitch_hi_next  = pitch_hi_reg;
        roll_lo_next   = roll_lo_reg;
        roll_hi_next   = roll_hi_reg;
        pitch_pct_next = pitch_pct_reg;
        roll_pct_next  = roll_pct_reg;
        mapped_next    = mapped_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        res_pitch_next = res_pitch_reg;
        res_roll_next  = res_roll_reg;
        pitch_out_next = pitch_out_reg;
        roll_out_next  = roll_out_reg;
        out_valid_next = out_valid_reg;
        div_req_next   = div_req_reg;
        div_req_next.start = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid)
        begin
            unique case (cfg_index)
                armn_pkg::CFG_PITCH_PERCENT: pitch_pct_next = cfg_data;
                armn_pkg::CFG_ROLL_PERCENT:  roll_pct_next  = cfg_data;
                default:                     pitch_pct_next = pitch_pct_reg;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    lon_next   = longitudinal_milli_g;
                    lat_next   = lateral_milli_g;
                    axis_next  = AXIS_PITCH;
                    state_next = ST_MARK;
                end
            end
            ST_MARK:
            begin
                if (axis_reg == AXIS_PITCH)
                begin
                    pitch_lo_next = lo_new;
                    pitch_hi_next = hi_new;
                end
                else
                begin
                    roll_lo_next = lo_new;
                    roll_hi_next = hi_new;
                end
                div_req_next.start = 1'b1;
                div_req_next.numer = armn_pkg::NUM_W'(diff_wide[SW-1:0]) *
                                     armn_pkg::NUM_W'(armn_pkg::MAP_SPAN);
                div_req_next.denom = span_wide[SW-1:0];
                state_next = ST_DIV_MAP;
            end
            ST_DIV_MAP:
            begin
                if (div_rsp.done)
                begin
                    mapped_next = $signed(div_rsp.quotient) -
                                  armn_pkg::OUT_W'(armn_pkg::MAP_OFFSET);
                    state_next  = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                neg_next   = prod[armn_pkg::PROD_W-1];
                mag_next   = prod_mag;
                state_next = ST_DIV_GAIN;
            end
            ST_DIV_GAIN:
            begin
                if (axis_reg == AXIS_PITCH)
                begin
                    res_pitch_next = drive;
                    axis_next      = AXIS_ROLL;
                    state_next     = ST_MARK;
                end
                else
                begin
                    res_roll_next = drive;
                    state_next    = ST_DELIVER;
                end
            end
            ST_DELIVER:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    pitch_out_next = res_pitch_reg;
                    roll_out_next  = res_roll_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= AXIS_PITCH;
            lon_reg       <= '0;
            lat_reg       <= '0;
            pitch_lo_reg  <= '0;
            pitch_hi_reg  <= SW'(1);
            roll_lo_reg   <= '0;
            roll_hi_reg   <= SW'(1);
            pitch_pct_reg <= armn_pkg::PCT_W'(armn_pkg::PERCENT_FULL);
            roll_pct_reg  <= armn_pkg::PCT_W'(armn_pkg::PERCENT_FULL);
            mapped_reg    <= '0;
            neg_reg       <= 1'b0;
            mag_reg       <= '0;
            res_pitch_reg <= '0;
            res_roll_reg  <= '0;
            pitch_out_reg <= '0;
            roll_out_reg  <= '0;
            out_valid_reg <= 1'b0;
            div_req_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            lon_reg       <= lon_next;
            lat_reg       <= lat_next;
            pitch_lo_reg  <= pitch_lo_next;
            pitch_hi_reg  <= pitch_hi_next;
            roll_lo_reg   <= roll_lo_next;
            roll_hi_reg   <= roll_hi_next;
            pitch_pct_reg <= pitch_pct_next;
            roll_pct_reg  <= roll_pct_next;
            mapped_reg    <= mapped_next;
            neg_reg       <= neg_next;
            mag_reg       <= mag_next;
            res_pitch_reg <= res_pitch_next;
            res_roll_reg  <= res_roll_next;
            pitch_out_reg <= pitch_out_next;
            roll_out_reg  <= roll_out_next;
            out_valid_reg <= out_valid_next;
            div_req_reg   <= div_req_next;
        end
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign pitch_drive = pitch_out_reg;
    assign roll_drive  = roll_out_reg;

    // The running range always straddles the reset marks.
    a_marks_straddle: assert property (@(posedge clk) disable iff (!rst_n)
        (pitch_lo_reg <= 0) && (pitch_hi_reg >= 1) &&
        (roll_lo_reg <= 0) && (roll_hi_reg >= 1))
        else $error("running range lost its reset marks");

    // A divider completion is only expected while the sequencer waits for one.
    a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV_MAP))
        else $error("divider completed outside a divide step");

    // A new result is only launched from the delivery step.
    a_launch_from_deliver: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DELIVER))
        else $error("result launched outside the delivery step");

    // An accepted transaction keeps the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input ready right after a transaction");

endmodule

FILE: verif/tb_auto_range_motion_normalizer.sv
// ----------------------------------------------------------------------------
// Auto-range motion normalizer testbench
// Sends acceleration samples through the input channel and gain settings
// through the register channel while an independent model tracks the running
// range and gains of each axis. Every drive-value transaction is checked
// against the oldest prediction. Directed samples cover the reset range, the
// gain extremes and the field extremes. Random traffic follows, with random
// idle cycles on both sides, one long receiver hold-off and several gain
// changes made while the block is idle.
// ----------------------------------------------------------------------------
module tb_auto_range_motion_normalizer;

    localparam int          CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned IDLE_PCT     = 17;
    localparam int          PHASE_COUNT  = 8;
    localparam int          PHASE_ITEMS  = 250;
    localparam int          SETTLE_LIMIT = 200;
    localparam longint      SAMPLE_MAX   = (longint'(1) << (armn_pkg::SAMPLE_WIDTH - 1)) - 1;
    localparam longint      SAMPLE_MIN   = -SAMPLE_MAX - 1;

    typedef struct packed {
        logic signed [armn_pkg::OUT_W-1:0] pitch;
        logic signed [armn_pkg::OUT_W-1:0] roll;
    } drive_pair_t;

    logic                                     clk;
    logic                                     rst_n;
    logic                                     in_valid;
    logic                                     in_ready;
    logic signed [armn_pkg::SAMPLE_WIDTH-1:0] longitudinal_milli_g;
    logic signed [armn_pkg::SAMPLE_WIDTH-1:0] lateral_milli_g;
    logic                                     out_valid;
    logic                                     out_ready;
    logic signed [armn_pkg::OUT_W-1:0]        pitch_drive;
    logic signed [armn_pkg::OUT_W-1:0]        roll_drive;
    logic                                     cfg_valid;
    logic                                     cfg_ready;
    logic [armn_pkg::CFG_IDX_W-1:0]           cfg_index;
    logic [armn_pkg::PCT_W-1:0]               cfg_data;

    drive_pair_t pending_drives[$];
    drive_pair_t oldest_drive;
    drive_pair_t next_drive;
    longint      pitch_low;
    longint      pitch_high;
    longint      roll_low;
    longint      roll_high;
    int          pitch_gain;
    int          roll_gain;
    int unsigned idle_pct;
    int          hold_cycles;
    int          mismatches;
    int          samples_sent;
    int          drives_checked;
    int          gain_writes;
    longint      cycle_count;

    auto_range_motion_normalizer dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_auto_range_motion_normalizer NOT OK");
            $finish;
        end
    end

    function automatic logic signed [armn_pkg::OUT_W-1:0] normalize_axis(
        input  logic signed [armn_pkg::SAMPLE_WIDTH-1:0] sample,
        inout  longint                                   low_mark,
        inout  longint                                   high_mark,
        input  int                                       gain);
        longint s;
        longint mapped;
        longint scaled;
        int     g;
        s = sample;
        g = (gain > armn_pkg::PERCENT_FULL) ? armn_pkg::PERCENT_FULL : gain;
        if (s < low_mark)
            low_mark = s;
        if (s > high_mark)
            high_mark = s;
        mapped = (s - low_mark) * armn_pkg::MAP_SPAN / (high_mark - low_mark)
                 - armn_pkg::MAP_OFFSET;
        scaled = mapped * g / armn_pkg::PERCENT_FULL;
        return scaled[armn_pkg::OUT_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch on %s at cycle %0d: got %0d, expected %0d",
                 what, cycle_count, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == armn_pkg::CFG_PITCH_PERCENT)
                    pitch_gain = cfg_data;
                else
                    roll_gain = cfg_data;
            end
            if (out_valid && out_ready)
            begin
                if (pending_drives.size() == 0)
                begin
                    report_mismatch("unexpected transaction", pitch_drive, 0);
                end
                else
                begin
                    oldest_drive = pending_drives.pop_front();
                    if (pitch_drive !== oldest_drive.pitch)
                        report_mismatch("pitch_drive", pitch_drive, oldest_drive.pitch);
                    if (roll_drive !== oldest_drive.roll)
                        report_mismatch("roll_drive", roll_drive, oldest_drive.roll);
                    drives_checked++;
                end
            end
            if (in_valid && in_ready)
            begin
                next_drive.pitch = normalize_axis(longitudinal_milli_g, pitch_low,
                                                  pitch_high, pitch_gain);
                next_drive.roll  = normalize_axis(lateral_milli_g, roll_low,
                                                  roll_high, roll_gain);
                pending_drives.push_back(next_drive);
                samples_sent++;
            end
        end
    end

    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ready = 1'b0;
                hold_cycles--;
            end
            else
            begin
                out_ready = ($urandom_range(99) >= idle_pct);
            end
        end
    end

    task automatic send_sample(input longint lon, input longint lat);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid             = 1'b1;
        longitudinal_milli_g = armn_pkg::SAMPLE_WIDTH'(lon);
        lateral_milli_g      = armn_pkg::SAMPLE_WIDTH'(lat);
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (pending_drives.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_register(input logic [armn_pkg::CFG_IDX_W-1:0] index,
                                  input logic [armn_pkg::PCT_W-1:0] value);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        gain_writes++;
    endtask

    task automatic set_gains(input int pitch_pct, input int roll_pct);
        wait_drained();
        write_register(armn_pkg::CFG_PITCH_PERCENT, armn_pkg::PCT_W'(pitch_pct));
        write_register(armn_pkg::CFG_ROLL_PERCENT, armn_pkg::PCT_W'(roll_pct));
    endtask

    function automatic logic signed [armn_pkg::SAMPLE_WIDTH-1:0] pick_sample();
        case ($urandom_range(19))
            0:       return {1'b1, {(armn_pkg::SAMPLE_WIDTH-1){1'b0}}};
            1:       return {1'b0, {(armn_pkg::SAMPLE_WIDTH-1){1'b1}}};
            2, 3:    return armn_pkg::SAMPLE_WIDTH'(int'($urandom_range(64)) - 32);
            default: return armn_pkg::SAMPLE_WIDTH'($urandom);
        endcase
    endfunction

    function automatic logic [armn_pkg::PCT_W-1:0] pick_gain();
        case ($urandom_range(5))
            0:       return '0;
            1:       return armn_pkg::PCT_W'(armn_pkg::PERCENT_FULL);
            2:       return '1;
            default: return armn_pkg::PCT_W'($urandom_range(127));
        endcase
    endfunction

    task automatic test_initial_range();
        send_sample(0, 0);
        send_sample(1, 1);
        send_sample(-1, 2);
        send_sample(1, -1);
        send_sample(3, -2);
        send_sample(0, 0);
    endtask

    task automatic test_gain_settings();
        set_gains(0, 127);
        send_sample(2, -3);
        send_sample(-4, 5);
        set_gains(101, 1);
        send_sample(7, -7);
        send_sample(-2, 6);
        set_gains(50, 99);
        send_sample(-5, 9);
        send_sample(4, -8);
        set_gains(127, 0);
        send_sample(10, -10);
        send_sample(-9, 11);
    endtask

    task automatic test_field_extremes();
        set_gains(armn_pkg::PERCENT_FULL, armn_pkg::PERCENT_FULL);
        send_sample(SAMPLE_MAX, SAMPLE_MIN);
        send_sample(SAMPLE_MIN, SAMPLE_MAX);
        send_sample(0, -1);
        send_sample(-1, 0);
        send_sample(SAMPLE_MAX, SAMPLE_MAX);
        send_sample(SAMPLE_MIN, SAMPLE_MIN);
    endtask

    task automatic test_backpressure();
        wait_drained();
        hold_cycles = 600;
        repeat (12)
            send_sample(pick_sample(), pick_sample());
        wait_drained();
        repeat (20)
            send_sample(pick_sample(), pick_sample());
        wait_drained();
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            if (phase == 0)
                set_gains(0, 127);
            else if (phase == 1)
                set_gains(127, 0);
            else
                set_gains(pick_gain(), pick_gain());
            idle_pct = (phase == 3) ? 0 : IDLE_PCT;
            repeat (PHASE_ITEMS)
                send_sample(pick_sample(), pick_sample());
        end
        idle_pct = IDLE_PCT;
    endtask

    initial
    begin
        rst_n                = 1'b0;
        in_valid             = 1'b0;
        longitudinal_milli_g = '0;
        lateral_milli_g      = '0;
        cfg_valid            = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        pitch_low            = 0;
        pitch_high           = 1;
        roll_low             = 0;
        roll_high            = 1;
        pitch_gain           = armn_pkg::PERCENT_FULL;
        roll_gain            = armn_pkg::PERCENT_FULL;
        idle_pct             = IDLE_PCT;
        hold_cycles          = 0;
        mismatches           = 0;
        samples_sent         = 0;
        drives_checked       = 0;
        gain_writes          = 0;
        cycle_count          = 0;
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_initial_range();
        test_gain_settings();
        test_field_extremes();
        test_backpressure();
        test_random_traffic();

        wait_drained();
        repeat (SETTLE_LIMIT)
            @(negedge clk);

        $display("covered %0d sample transactions, %0d checked drive transactions",
                 samples_sent, drives_checked);
        $display("with %0d gain writes including 0, 100 and 127, and a long output hold-off",
                 gain_writes);
        if (mismatches == 0)
            $display("tb_auto_range_motion_normalizer OK");
        else
            $display("tb_auto_range_motion_normalizer NOT OK");
        $finish;
    end

endmodule
